// ----- hw/rtl/vcar_pkg.sv -----
// ----------------------------------------------------------------------------
// vcar_pkg
// Shared widths, constants, state encoding and control/status bundles for
// the velocity cap with acceleration repair block.
// ----------------------------------------------------------------------------
`default_nettype none

package vcar_pkg;

  // Field widths of one trajectory point.
  localparam int VW        = 18;                     // velocity / acceleration
  localparam int TDATA_W   = ((2 * VW + 7) / 8) * 8; // packed and byte aligned
  localparam int PAD_W     = TDATA_W - 2 * VW;

  // The capped velocity step is always smaller than the original one, so the
  // quotient stays below the acceleration magnitude (at most 2^17).
  localparam int QUO_W     = VW - 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PROD_W    = 2 * VW;

  localparam logic signed [VW-1:0] MAX_VEL_RESET = VW'(15360);
  localparam logic signed [VW-1:0] ACC_MAX       = VW'(131071);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_ROUND,
    ST_EMIT_HELD,
    ST_EMIT_LAST
  } vcar_state_t;

  typedef struct packed {
    logic accept;     // latch the incoming point
    logic decide;     // register differences and magnitudes
    logic start_mul;  // register product and load the divider
    logic div_step;   // one restoring division step
    logic round;      // round, sign and saturate the quotient
    logic load_held;  // push the held point into the output register
    logic load_last;  // push the final point into the output register
  } vcar_cmd_t;

  typedef struct packed {
    logic cur_valid;  // a held point is being emitted
    logic one_over;   // exactly one of the pair is over the cap
    logic last_flag;  // the accepted point closes the trajectory
    logic div_done;   // last division step in progress
    logic out_free;   // output register can take a transaction
  } vcar_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/velocity_cap_with_accel_repair.sv -----
// ----------------------------------------------------------------------------
// velocity_cap_with_accel_repair
// Velocity cap on a stream of trajectory points with acceleration repair at
// the boundaries between capped and uncapped points.
// ----------------------------------------------------------------------------
// Each point is held until its successor arrives, then leaves with its
// velocity capped to the velocity limit. Its acceleration becomes 0 when both
// it and its successor are over the cap, stays as it is when neither is, and
// is recomputed as (capped dv) * max(|a|,1) / |original dv|, rounded to
// nearest with ties away from zero and saturated, when exactly one is. A
// point marked last leaves right after its predecessor with acceleration 0
// and tlast set, and nothing stays held. A repaired point goes through
// accept, decide, multiply, the 17 steps of the restoring divider, round
// and emit before the next point can be taken; a point without repair skips
// multiply, divide and round, the first point of a trajectory stops after
// decide, and a last point adds one more emit. An emit also waits while the
// output register holds a result that the receiver has not taken. One
// finished result may wait in the output register while the next point is
// accepted. The velocity limit is written through cfg_wen/cfg_wdata by the
// user, only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_cap_with_accel_repair (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration: velocity limit
  input  wire logic                          cfg_wen,
  input  wire logic [vcar_pkg::VW-1:0]       cfg_wdata,
  // Input points
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [17:0] point_velocity, [35:18] point_accel, [39:36] zero
  input  wire logic [vcar_pkg::TDATA_W-1:0]  s_axis_tdata,
  input  wire logic                          s_axis_tlast,   // point_last
  // Output points
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [17:0] out_velocity, [35:18] out_accel, [39:36] zero
  output logic [vcar_pkg::TDATA_W-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast    // out_last
);
  import vcar_pkg::*;

  vcar_cmd_t     cmd;
  vcar_sts_t     sts;
  logic [VW-1:0] out_velocity;
  logic [VW-1:0] out_accel;

  // Sequence each point through decide, multiply, divide and emit.
  vcar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the points, do the arithmetic and drive the output register.
  vcar_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .in_velocity  (s_axis_tdata[VW-1:0]),
    .in_accel     (s_axis_tdata[2*VW-1:VW]),
    .in_last      (s_axis_tlast),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_velocity (out_velocity),
    .out_accel    (out_accel),
    .out_last     (m_axis_tlast)
  );

  // Pack the result fields, pad the top bits with zeros.
  assign m_axis_tdata = {PAD_W'(0), out_accel, out_velocity};

endmodule

`default_nettype wire

// ----- hw/rtl/vcar_ctrl.sv -----
// ----------------------------------------------------------------------------
// vcar_ctrl
// Sequencer: accept a point, decide the repair path, run the divider and
// hand the results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcar_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire vcar_pkg::vcar_sts_t sts,
  output vcar_pkg::vcar_cmd_t    cmd
);
  import vcar_pkg::*;

  vcar_state_t state;
  vcar_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.cur_valid && sts.one_over) state_next = ST_MUL;
        else if (sts.cur_valid)            state_next = ST_EMIT_HELD;
        else if (sts.last_flag)            state_next = ST_EMIT_LAST;
        else                               state_next = ST_IDLE;
      end
      ST_MUL:   state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) state_next = ST_ROUND;
      end
      ST_ROUND: state_next = ST_EMIT_HELD;
      ST_EMIT_HELD: begin
        if (sts.out_free) state_next = sts.last_flag ? ST_EMIT_LAST : ST_IDLE;
      end
      ST_EMIT_LAST: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = !rst;
        cmd.accept = in_valid && !rst;
      end
      ST_DECIDE:    cmd.decide    = 1'b1;
      ST_MUL:       cmd.start_mul = 1'b1;
      ST_DIV:       cmd.div_step  = 1'b1;
      ST_ROUND:     cmd.round     = 1'b1;
      ST_EMIT_HELD: cmd.load_held = sts.out_free;
      ST_EMIT_LAST: cmd.load_last = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vcar_dp.sv -----
// ----------------------------------------------------------------------------
// vcar_dp
// Datapath: held point, velocity cap, multiply and restoring divide for the
// acceleration repair, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vcar_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wen,
  input  wire logic [vcar_pkg::VW-1:0]    cfg_wdata,
  input  wire logic [vcar_pkg::VW-1:0]    in_velocity,
  input  wire logic [vcar_pkg::VW-1:0]    in_accel,
  input  wire logic                       in_last,
  input  wire vcar_pkg::vcar_cmd_t        cmd,
  output vcar_pkg::vcar_sts_t             sts,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [vcar_pkg::VW-1:0]         out_velocity,
  output logic [vcar_pkg::VW-1:0]         out_accel,
  output logic                            out_last
);
  import vcar_pkg::*;

  logic signed [VW-1:0] vel_limit;

  // Held point (successor of cur once accepted) and the point being emitted.
  logic                 held_valid;
  logic signed [VW-1:0] held_v;
  logic signed [VW-1:0] held_a;
  logic                 cur_valid;
  logic signed [VW-1:0] cur_v;
  logic signed [VW-1:0] cur_a;
  logic                 last_flag;

  // Repair arithmetic.
  logic [VW-1:0]        dv;
  logic [VW-1:0]        dcap_mag;
  logic [VW-1:0]        den;
  logic                 neg;
  logic [VW-1:0]        rem;
  logic [QUO_W-1:0]     mag_lo;
  logic [QUO_W-1:0]     quo;
  logic [CNT_W-1:0]     cnt;
  logic signed [VW-1:0] acc_rep;

  logic                 c_over;
  logic                 n_over;
  logic signed [VW-1:0] cc;
  logic signed [VW-1:0] cn;
  logic signed [VW:0]   dv_s;
  logic signed [VW:0]   dcap_s;
  logic signed [VW:0]   a_abs;
  logic [PROD_W-1:0]    prod;
  logic [VW:0]          trial;
  logic                 trial_ge;
  logic [VW-1:0]        q_round;
  logic                 round_up;
  logic signed [VW-1:0] held_acc_sel;

  always_comb begin
    c_over   = cur_v > vel_limit;
    n_over   = held_v > vel_limit;
    cc       = c_over ? vel_limit : cur_v;
    cn       = n_over ? vel_limit : held_v;
    dv_s     = {held_v[VW-1], held_v} - {cur_v[VW-1], cur_v};
    dcap_s   = {cn[VW-1], cn} - {cc[VW-1], cc};
    a_abs    = cur_a[VW-1] ? -{cur_a[VW-1], cur_a} : {cur_a[VW-1], cur_a};
    prod     = PROD_W'(dcap_mag) * PROD_W'(den);
    trial    = {rem, mag_lo[QUO_W-1]};
    trial_ge = trial >= {1'b0, dv};
    round_up = {rem, 1'b0} >= {1'b0, dv};
    q_round  = {1'b0, quo} + VW'(round_up);
  end

  always_comb begin
    if (c_over && n_over)        held_acc_sel = '0;
    else if (!c_over && !n_over) held_acc_sel = cur_a;
    else                         held_acc_sel = acc_rep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_limit <= MAX_VEL_RESET;
    end else if (cfg_wen) begin
      vel_limit <= cfg_wdata;
    end
  end

  // Hold control: the previous point moves to cur, the input becomes held.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      cur_valid  <= 1'b0;
      last_flag  <= 1'b0;
    end else if (cmd.accept) begin
      held_valid <= !in_last;
      cur_valid  <= held_valid;
      last_flag  <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_v  <= held_v;
      cur_a  <= held_a;
      held_v <= in_velocity;
      held_a <= in_accel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      dv       <= dv_s[VW] ? VW'(-dv_s) : dv_s[VW-1:0];
      dcap_mag <= dcap_s[VW] ? VW'(-dcap_s) : dcap_s[VW-1:0];
      neg      <= dcap_s[VW];
      den      <= (a_abs == '0) ? VW'(1) : a_abs[VW-1:0];
    end
    if (cmd.start_mul) begin
      rem    <= prod[2*VW-2:QUO_W];
      mag_lo <= prod[QUO_W-1:0];
      cnt    <= CNT_W'(DIV_STEPS - 1);
    end else if (cmd.div_step) begin
      rem    <= trial_ge ? VW'(trial - {1'b0, dv}) : trial[VW-1:0];
      quo    <= {quo[QUO_W-2:0], trial_ge};
      mag_lo <= {mag_lo[QUO_W-2:0], 1'b0};
      cnt    <= cnt - CNT_W'(1);
    end
    if (cmd.round) begin
      if (neg)                  acc_rep <= -q_round;
      else if (q_round[VW-1])   acc_rep <= ACC_MAX;
      else                      acc_rep <= q_round;
    end
  end

  // Output register: one result waits here while the next point is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_held || cmd.load_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_held) begin
      out_velocity <= cc;
      out_accel    <= held_acc_sel;
      out_last     <= 1'b0;
    end else if (cmd.load_last) begin
      out_velocity <= cn;
      out_accel    <= '0;
      out_last     <= 1'b1;
    end
  end

  always_comb begin
    sts.cur_valid = cur_valid;
    sts.one_over  = c_over != n_over;
    sts.last_flag = last_flag;
    sts.div_done  = cnt == '0;
    sts.out_free  = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_held || cmd.load_last) |-> (!out_valid || out_ready))
    else $error("output register overwritten while a result waits");

  a_rem_below_dv: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < dv))
    else $error("divider remainder not below divisor");

  a_round_sign: assert property (@(posedge clk) disable iff (rst)
    (cmd.round && neg) |=> (acc_rep[VW-1] || acc_rep == '0))
    else $error("repaired acceleration has wrong sign");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_held && cmd.load_last))
    else $error("two results loaded in one cycle");
`endif

endmodule

`default_nettype wire
